// ----- hdl/rano_pkg.sv -----
package rano_pkg;

    // Noise fraction width: noise is the tempered word's top bits as a fraction of one
    localparam int NOISE_FRAC_BITS = 16;
    localparam int NOISE_W         = NOISE_FRAC_BITS + 1;
    localparam int AMT_W           = 17;
    localparam int AMT_FRAC_BITS   = 16;
    localparam int SCALE_W         = NOISE_W + AMT_W;
    localparam int WIDE_W          = NOISE_FRAC_BITS + 9;

    localparam int TW_N      = 624;
    localparam int TW_M      = 397;
    localparam int TW_ADDR_W = $clog2(TW_N);
    localparam int WORD_W    = 32;

    localparam logic [WORD_W-1:0] TW_RESET_SEED = 32'd5489;
    localparam logic [WORD_W-1:0] TW_INIT_MULT  = 32'd1812433253;
    localparam logic [WORD_W-1:0] TW_MATRIX_A   = 32'h9908B0DF;
    localparam logic [WORD_W-1:0] TW_TEMPER_B   = 32'h9D2C5680;
    localparam logic [WORD_W-1:0] TW_TEMPER_C   = 32'hEFC60000;

    localparam logic [AMT_W-1:0] AMT_FULL = AMT_W'(1 << AMT_FRAC_BITS);

    typedef enum logic [1:0] {
        REG_SEED       = 2'd0,
        REG_NOISE_MODE = 2'd1,
        REG_AMOUNT     = 2'd2,
        REG_HANDLING   = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        HANDLE_ADD  = 2'd0,
        HANDLE_SUB  = 2'd1,
        HANDLE_MUL  = 2'd2,
        HANDLE_PASS = 2'd3
    } handling_t;

    typedef enum logic [2:0] {
        ST_SEED0,
        ST_SEED,
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_MUL,
        ST_FIN
    } ctrl_state_t;

    typedef struct packed {
        logic capture;      // take the input transaction
        logic seed_first;   // write word 0 of the table
        logic seed_boot;    // use the power-on seed instead of the register
        logic seed_step;    // write the next word of the table
        logic draw;         // twist one word and latch its noise
        logic draw_binary;  // latch the noise as zero or one
        logic scale;        // multiply noise by amount
        logic out_load;     // load the result register
    } ctrl_cmd_t;

    typedef struct packed {
        logic seed_last;
        logic binary_mode;
        logic out_stall;
    } dp_status_t;

endpackage

// ----- hdl/random_alpha_noise_unit.sv -----
// Alpha noise unit: each transaction carries one pixel's alpha byte and returns
// one new alpha byte, with noise from an MT19937 generator whose 624-word table
// lives in a two-read, one-write RAM; each draw reads two words and writes one
// back. From acceptance a pixel passes the draw, scale and load states to the
// result register in uniform mode; binary mode adds a read and a second draw.
// A pixel with frame_start set first rebuilds the table from the seed register,
// one word per cycle through the init multiplier. After reset the table is
// built from the default seed in the same way, with s_ready low throughout,
// while configuration writes are taken. The next pixel is accepted as soon as
// its result is loaded, even while that result still waits on m_ready.
// Configuration must be written only while idle; the block does not enforce it.
module random_alpha_noise_unit import rano_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_alpha_in,
    input  logic        s_frame_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_alpha_out
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    rano_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_frame_start (s_frame_start),
        .status        (status),
        .cmd           (cmd)
    );

    rano_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_alpha_in  (s_alpha_in),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_alpha_out (m_alpha_out),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ----- hdl/rano_ram.sv -----
module rano_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    output logic [WIDTH-1:0]  rd_data_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ----- hdl/rano_ctrl.sv -----
module rano_ctrl import rano_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_frame_start,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic        boot_reg, boot_next;
    logic        draw2_reg, draw2_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SEED0;
            boot_reg  <= 1'b1;
            draw2_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            boot_reg  <= boot_next;
            draw2_reg <= draw2_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        boot_next  = boot_reg;
        draw2_next = draw2_reg;
        unique case (state_reg)
            ST_SEED0: state_next = ST_SEED;
            ST_SEED: begin
                if (status.seed_last) begin
                    boot_next  = 1'b0;
                    state_next = boot_reg ? ST_IDLE : ST_RD;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    draw2_next = 1'b0;
                    // reads for the first draw are already under way
                    state_next = s_frame_start ? ST_SEED0 : ST_WR;
                end
            end
            ST_RD: state_next = ST_WR;
            ST_WR: begin
                if (status.binary_mode && !draw2_reg) begin
                    draw2_next = 1'b1;
                    state_next = ST_RD;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: state_next = ST_FIN;
            ST_FIN: begin
                if (!status.out_stall) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd             = '0;
        s_ready         = 1'b0;
        cmd.seed_boot   = boot_reg;
        cmd.draw_binary = draw2_reg;
        unique case (state_reg)
            ST_SEED0: cmd.seed_first = 1'b1;
            ST_SEED:  cmd.seed_step  = 1'b1;
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_RD:  ;
            ST_WR:  cmd.draw  = 1'b1;
            ST_MUL: cmd.scale = 1'b1;
            ST_FIN: cmd.out_load = !status.out_stall;
            default: ;
        endcase
    end

endmodule

// ----- hdl/rano_dp.sv -----
module rano_dp import rano_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wr_data,
    input  logic [7:0]  s_alpha_in,
    input  logic        m_ready,
    output logic        m_valid,
    output logic [7:0]  m_alpha_out,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  status
);

    localparam logic [NOISE_W-1:0] ONE_Q = NOISE_W'(1 << NOISE_FRAC_BITS);

    // configuration
    logic [WORD_W-1:0] seed_reg;
    logic              noise_mode_reg;
    logic [AMT_W-1:0]  amount_reg;
    handling_t         handling_reg;

    // generator
    logic [TW_ADDR_W-1:0] index_reg;
    logic [TW_ADDR_W-1:0] seed_cnt_reg;
    logic [WORD_W-1:0]    cur_reg;    // always mirrors table[index]
    logic [WORD_W-1:0]    word_reg;   // previous word of the init sweep

    // arithmetic
    logic [7:0]         alpha_reg;
    logic [NOISE_W-1:0] noise_reg;
    logic [NOISE_W-1:0] s_reg;
    logic [7:0]         out_reg;
    logic               m_valid_reg;

    logic [TW_ADDR_W-1:0] rd_addr_j1, rd_addr_j2;
    logic [TW_ADDR_W:0]   j2_sum;
    logic [WORD_W-1:0]    rd_j1, rd_j2;
    logic                 ram_we;
    logic [TW_ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;

    logic [WORD_W-1:0] seed_val;
    logic [WORD_W-1:0] seed_mix;
    logic [WORD_W-1:0] init_next;
    logic [WORD_W-1:0] twist_y;
    logic [WORD_W-1:0] twist_v;
    logic [WORD_W-1:0] tmp_a, tmp_b, tmp_c, tempered;
    logic [NOISE_W-1:0] noise_next;

    logic [AMT_W-1:0]   amt_clamped;
    logic [SCALE_W-1:0] scale_prod;

    logic [WIDE_W-1:0]  a_wide, s255, add_sum, sub_diff, mul_prod;
    logic [NOISE_W-1:0] one_minus_s;
    logic [7:0]         result;

    // read addresses follow the index: next word and the word M ahead
    assign j2_sum     = {1'b0, index_reg} + (TW_ADDR_W + 1)'(TW_M);
    assign rd_addr_j1 = (index_reg == TW_ADDR_W'(TW_N - 1)) ? '0 : index_reg + 1'b1;
    assign rd_addr_j2 = (j2_sum >= (TW_ADDR_W + 1)'(TW_N)) ?
                        TW_ADDR_W'(j2_sum - (TW_ADDR_W + 1)'(TW_N)) : j2_sum[TW_ADDR_W-1:0];

    assign seed_val  = cmd.seed_boot ? TW_RESET_SEED : seed_reg;
    assign seed_mix  = word_reg ^ (word_reg >> 30);
    assign init_next = WORD_W'(seed_mix * TW_INIT_MULT) + WORD_W'(seed_cnt_reg);

    assign twist_y  = {cur_reg[31], rd_j1[30:0]};
    assign twist_v  = rd_j2 ^ (twist_y >> 1) ^ (twist_y[0] ? TW_MATRIX_A : '0);
    assign tmp_a    = twist_v ^ (twist_v >> 11);
    assign tmp_b    = tmp_a ^ ((tmp_a << 7) & TW_TEMPER_B);
    assign tmp_c    = tmp_b ^ ((tmp_b << 15) & TW_TEMPER_C);
    assign tempered = tmp_c ^ (tmp_c >> 18);

    assign noise_next = cmd.draw_binary ? {tempered[WORD_W-1], {NOISE_FRAC_BITS{1'b0}}}
                                        : {1'b0, tempered[WORD_W-1 -: NOISE_FRAC_BITS]};

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = index_reg;
        ram_wdata = twist_v;
        if (cmd.seed_first) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = seed_val;
        end else if (cmd.seed_step) begin
            ram_we    = 1'b1;
            ram_waddr = seed_cnt_reg;
            ram_wdata = init_next;
        end else if (cmd.draw) begin
            ram_we = 1'b1;
        end
    end

    rano_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TW_N)
    ) u_table (
        .aclk      (aclk),
        .wr_en     (ram_we),
        .wr_addr   (ram_waddr),
        .wr_data   (ram_wdata),
        .rd_addr_a (rd_addr_j1),
        .rd_data_a (rd_j1),
        .rd_addr_b (rd_addr_j2),
        .rd_data_b (rd_j2)
    );

    // scale: saturate amount at full, then take Q1.16 product
    assign amt_clamped = (amount_reg > AMT_FULL) ? AMT_FULL : amount_reg;
    assign scale_prod  = SCALE_W'(noise_reg) * SCALE_W'(amt_clamped);

    // final stage: a*2^F plus or minus 255*s, or a*(1 - s), or a unchanged in pass mode
    assign a_wide      = {1'b0, alpha_reg, {NOISE_FRAC_BITS{1'b0}}};
    assign s255        = {s_reg, 8'd0} - {8'd0, s_reg};
    assign add_sum     = a_wide + s255;
    assign sub_diff    = a_wide - s255;
    assign one_minus_s = ONE_Q - s_reg;
    assign mul_prod    = WIDE_W'(alpha_reg) * WIDE_W'(one_minus_s);

    always_comb begin
        case (handling_reg)
            HANDLE_ADD: begin
                result = add_sum[NOISE_FRAC_BITS+8] ? 8'hFF
                                                    : add_sum[NOISE_FRAC_BITS +: 8];
            end
            HANDLE_SUB: begin
                result = (a_wide > s255) ? sub_diff[NOISE_FRAC_BITS +: 8] : 8'd0;
            end
            HANDLE_MUL: result = mul_prod[NOISE_FRAC_BITS +: 8];
            default:    result = alpha_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg       <= TW_RESET_SEED;
            noise_mode_reg <= 1'b0;
            amount_reg     <= AMT_W'(16384);
            handling_reg   <= HANDLE_ADD;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_SEED:       seed_reg       <= cfg_wr_data;
                REG_NOISE_MODE: noise_mode_reg <= cfg_wr_data[0];
                REG_AMOUNT:     amount_reg     <= cfg_wr_data[AMT_W-1:0];
                REG_HANDLING:   handling_reg   <= handling_t'(cfg_wr_data[1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg    <= '0;
            seed_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.seed_first) begin
                index_reg    <= '0;
                seed_cnt_reg <= TW_ADDR_W'(1);
            end else if (cmd.seed_step) begin
                seed_cnt_reg <= seed_cnt_reg + 1'b1;
            end else if (cmd.draw) begin
                index_reg <= rd_addr_j1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.seed_first) begin
            word_reg <= seed_val;
            cur_reg  <= seed_val;
        end else if (cmd.seed_step) begin
            word_reg <= init_next;
        end else if (cmd.draw) begin
            // the next word was untouched since it was read: keep it as current
            cur_reg <= rd_j1;
        end
        if (cmd.capture) begin
            alpha_reg <= s_alpha_in;
        end
        if (cmd.draw) begin
            noise_reg <= noise_next;
        end
        if (cmd.scale) begin
            s_reg <= scale_prod[AMT_FRAC_BITS +: NOISE_W];
        end
        if (cmd.out_load) begin
            out_reg <= result;
        end
    end

    assign status.seed_last   = (seed_cnt_reg == TW_ADDR_W'(TW_N - 1));
    assign status.binary_mode = noise_mode_reg;
    assign status.out_stall   = m_valid_reg && !m_ready;

    assign m_valid     = m_valid_reg;
    assign m_alpha_out = out_reg;

endmodule
